// ----- design/cnm_pkg.sv -----
// cnm_pkg: shared constants, state types and the score status struct
// for the cosine nearest match block; no dependencies
`timescale 1ns / 1ps

package cnm_pkg;

   localparam int TABLE_DEPTH_DEF   = 64;
   localparam int VECTOR_LENGTH_DEF = 128;
   localparam int ELEMENT_WIDTH_DEF = 16;

   localparam int THRESH_WIDTH = 15;
   localparam int LIMIT_WIDTH  = 7;
   localparam int CSR_WIDTH    = 15;
   localparam int SCORE_WIDTH  = 16;
   localparam int COUNT_WIDTH  = 32;

   // 0.001 at 24 fraction bits
   localparam int NORM_FLOOR = 16777;

   localparam logic [THRESH_WIDTH-1:0] DEFAULT_THRESHOLD = 15'd22938;
   localparam logic [LIMIT_WIDTH-1:0]  LIMIT_RESET       = 7'd64;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_LIMIT     = 1'b1;

   localparam logic MODE_ENROLL = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_ROW,
      ST_RD,
      ST_DOT,
      ST_NA,
      ST_NB,
      ST_START,
      ST_WAIT,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_MUL,
      SC_SQRT,
      SC_PRE,
      SC_DIV,
      SC_FIN,
      SC_DONE
   } score_state_type;

   typedef struct packed {
      logic                          done;
      logic signed [SCORE_WIDTH-1:0] score;
   } score_stat_type;

endpackage

// ----- design/cnm_if.sv -----
// cnm_req_if / cnm_rsp_if: valid-ready channels for element words and
// result words of the cosine nearest match block; no dependencies
`timescale 1ns / 1ps

interface cnm_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [15:0] element;
   logic               last;

   modport source (output valid, mode, element, last, input ready);
   modport sink   (input valid, mode, element, last, output ready);
endinterface

interface cnm_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic               table_full;
   logic               matched;
   logic [5:0]         person_index;
   logic signed [15:0] similarity;
   logic [31:0]        seen_count;
   logic [6:0]         enrolled;

   modport source (output valid, kind, table_full, matched, person_index, similarity,
                   seen_count, enrolled, input ready);
   modport sink   (input valid, kind, table_full, matched, person_index, similarity,
                   seen_count, enrolled, output ready);
endinterface

// ----- design/cosine_nearest_match.sv -----
// cosine_nearest_match: enrolls vectors into a row table and scores query
// vectors by cosine similarity; uses cnm_pkg, cnm_if and cnm_score
//
//   channel  dir  payload                                           handshake
//   req_ch   in   mode, element, last                               valid/ready
//   rsp_ch   out  kind, table_full, matched, person_index,
//                 similarity, seen_count, enrolled                  valid/ready
//   csr_*    in   csr_index, csr_data                               csr_write_en
//
// a word that is not last is taken while idle; an enroll last word with
// room in the table zero-fills the rest of the row (n words sent)
// a query last word scores each enrolled row: one shared multiplier does dot
// and norms per element in the states read, dot, query norm and row norm,
// then the serial multiply, root and divide of the score unit
// reset is synchronous and needs no clearing pass; a waiting result word
// stalls only the next last word, other words are taken meanwhile
`timescale 1ns / 1ps

module cosine_nearest_match import cnm_pkg::*; #(
   parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
   parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic                 csr_index,
   input  logic [CSR_WIDTH-1:0] csr_data,
   cnm_req_if.sink              req_ch,
   cnm_rsp_if.source            rsp_ch
);

   localparam int EW  = ELEMENT_WIDTH;
   localparam int VL  = VECTOR_LENGTH;
   localparam int TD  = TABLE_DEPTH;
   localparam int NW  = 2 * EW + $clog2(VL);
   localparam int IW  = (VL > 1) ? $clog2(VL) : 1;
   localparam int PW  = $clog2(VL + 1);
   localparam int RW  = (TD > 1) ? $clog2(TD) : 1;
   localparam int CW  = $clog2(TD + 1);
   localparam int AW  = (TD * VL > 1) ? $clog2(TD * VL) : 1;
   localparam int LMW = (CW > LIMIT_WIDTH) ? CW : LIMIT_WIDTH;

   state_type state_ff, state_in;

   logic [THRESH_WIDTH-1:0] thr_ff, thr_in;
   logic [LIMIT_WIDTH-1:0]  limit_ff, limit_in;
   logic [CW-1:0]           enrolled_ff, enrolled_in;
   logic [PW-1:0]           pos_ff, pos_in;
   logic                    mode_ff, mode_in;
   logic [PW-1:0]           dim_ff, dim_in;
   logic [PW-1:0]           e_ff, e_in;
   logic [CW-1:0]           row_ff, row_in;
   logic signed [NW:0]      dot_ff, dot_in;
   logic [NW-1:0]           na_ff, na_in;
   logic [NW-1:0]           nb_ff, nb_in;
   logic signed [SCORE_WIDTH-1:0] best_ff, best_in;
   logic [CW-1:0]           best_row_ff, best_row_in;
   logic                    found_ff, found_in;
   logic                    full_ff, full_in;
   logic                    matched_ff, matched_in;
   logic [COUNT_WIDTH-1:0]  seen_ff, seen_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic                    rsp_full_ff, rsp_full_in;
   logic                    rsp_matched_ff, rsp_matched_in;
   logic [5:0]              rsp_index_ff, rsp_index_in;
   logic signed [SCORE_WIDTH-1:0] rsp_sim_ff, rsp_sim_in;
   logic [COUNT_WIDTH-1:0]  rsp_seen_ff, rsp_seen_in;
   logic [LIMIT_WIDTH-1:0]  rsp_enrolled_ff, rsp_enrolled_in;

   // stores
   logic signed [EW-1:0]   vmem [TD*VL];
   logic signed [EW-1:0]   qmem [VL];
   logic [COUNT_WIDTH-1:0] cmem [TD];
   logic signed [EW-1:0]   v_data_ff;
   logic signed [EW-1:0]   q_data_ff;
   logic [COUNT_WIDTH-1:0] c_data_ff;

   logic                   vm_we;
   logic [AW-1:0]          vm_waddr;
   logic signed [EW-1:0]   vm_wdata;
   logic                   qm_we;
   logic                   cm_we;
   logic [COUNT_WIDTH-1:0] cm_wdata;
   logic [AW-1:0]          vm_raddr;
   logic                   score_start;
   logic                   rsp_load;

   logic                   req_fire;
   logic                   cur_mode;
   logic                   in_range;
   logic [PW-1:0]          pos_next;
   logic [LMW-1:0]         limit_eff;
   logic                   room;
   logic signed [EW-1:0]   elem_val;
   logic signed [EW-1:0]   op_a, op_b;
   logic signed [2*EW-1:0] prod;
   logic [THRESH_WIDTH-1:0] thr_eff;
   logic                   meets;
   logic                   last_elem;
   score_stat_type         stat;

   generate
      if (EW > 16) begin : g_wide
         assign elem_val = EW'($unsigned(req_ch.element));
      end else begin : g_narrow
         assign elem_val = req_ch.element[EW-1:0];
      end
   endgenerate

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign cur_mode  = (pos_ff == '0) ? req_ch.mode : mode_ff;
   assign in_range  = pos_ff < PW'(VL);
   assign pos_next  = in_range ? pos_ff + 1'b1 : pos_ff;
   assign limit_eff = ((limit_ff == '0) || (LMW'(limit_ff) > LMW'(TD))) ?
                      LMW'(TD) : LMW'(limit_ff);
   assign room      = LMW'(enrolled_ff) < limit_eff;
   assign thr_eff   = (thr_ff == '0) ? DEFAULT_THRESHOLD : thr_ff;
   assign meets     = found_ff && ($unsigned(best_ff) >= {1'b0, thr_eff});
   assign last_elem = (e_ff + 1'b1) >= dim_ff;
   assign vm_raddr  = AW'(RW'(row_ff)) * AW'(VL) + AW'(e_ff[IW-1:0]);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // shared multiplier: dot, then query norm, then row norm
   always_comb begin
      op_a = q_data_ff;
      op_b = v_data_ff;
      case (state_ff)
         ST_NA: begin
            op_a = q_data_ff;
            op_b = q_data_ff;
         end
         ST_NB: begin
            op_a = v_data_ff;
            op_b = v_data_ff;
         end
         default: begin
         end
      endcase
   end
   assign prod = op_a * op_b;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_ch.last) begin
               if (cur_mode == MODE_QUERY) state_in = ST_ROW;
               else if (room)              state_in = ST_FILL;
               else                        state_in = ST_DONE;
            end
         end
         ST_FILL:   if (e_ff >= PW'(VL)) state_in = ST_DONE;
         ST_ROW: begin
            if (row_ff < enrolled_ff) state_in = ST_RD;
            else                      state_in = meets ? ST_CNT_RD : ST_DONE;
         end
         ST_RD:     state_in = ST_DOT;
         ST_DOT:    state_in = ST_NA;
         ST_NA:     state_in = ST_NB;
         ST_NB:     state_in = last_elem ? ST_START : ST_RD;
         ST_START:  state_in = ST_WAIT;
         ST_WAIT:   if (stat.done) state_in = ST_ROW;
         ST_CNT_RD: state_in = ST_CNT_WR;
         ST_CNT_WR: state_in = ST_DONE;
         ST_DONE:   if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ch.ready = state_ff == ST_IDLE;
      vm_we        = 1'b0;
      vm_waddr     = AW'(RW'(enrolled_ff)) * AW'(VL) + AW'(pos_ff[IW-1:0]);
      vm_wdata     = elem_val;
      qm_we        = 1'b0;
      cm_we        = 1'b0;
      cm_wdata     = '0;
      score_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && in_range) begin
               vm_we = (cur_mode == MODE_ENROLL) && room;
               qm_we = cur_mode == MODE_QUERY;
            end
         end
         ST_FILL: begin
            vm_waddr = AW'(RW'(enrolled_ff)) * AW'(VL) + AW'(e_ff[IW-1:0]);
            vm_wdata = '0;
            vm_we    = e_ff < PW'(VL);
            cm_we    = e_ff >= PW'(VL);
         end
         ST_START: score_start = 1'b1;
         ST_CNT_WR: begin
            cm_we    = 1'b1;
            cm_wdata = (c_data_ff == '1) ? c_data_ff : c_data_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      thr_in      = thr_ff;
      limit_in    = limit_ff;
      enrolled_in = enrolled_ff;
      pos_in      = pos_ff;
      mode_in     = mode_ff;
      dim_in      = dim_ff;
      e_in        = e_ff;
      row_in      = row_ff;
      dot_in      = dot_ff;
      na_in       = na_ff;
      nb_in       = nb_ff;
      best_in     = best_ff;
      best_row_in = best_row_ff;
      found_in    = found_ff;
      full_in     = full_ff;
      matched_in  = matched_ff;
      seen_in     = seen_ff;

      if (csr_write_en) begin
         if (csr_index == CSR_THRESHOLD) thr_in = csr_data[THRESH_WIDTH-1:0];
         else                            limit_in = csr_data[LIMIT_WIDTH-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in = cur_mode;
               pos_in  = pos_next;
               if (req_ch.last) begin
                  pos_in      = '0;
                  dim_in      = pos_next;
                  e_in        = pos_next;
                  row_in      = '0;
                  best_in     = '0;
                  best_row_in = '0;
                  found_in    = 1'b0;
                  matched_in  = 1'b0;
                  seen_in     = '0;
                  full_in     = (cur_mode == MODE_ENROLL) && !room;
               end
            end
         end
         ST_FILL: begin
            if (e_ff < PW'(VL)) e_in = e_ff + 1'b1;
            else                enrolled_in = enrolled_ff + 1'b1;
         end
         ST_ROW: begin
            e_in   = '0;
            dot_in = '0;
            na_in  = '0;
            nb_in  = '0;
         end
         ST_DOT: dot_in = dot_ff + (NW+1)'(prod);
         ST_NA:  na_in  = na_ff + NW'($unsigned(prod));
         ST_NB: begin
            nb_in = nb_ff + NW'($unsigned(prod));
            e_in  = e_ff + 1'b1;
         end
         ST_WAIT: begin
            if (stat.done) begin
               if (stat.score > best_ff) begin
                  best_in     = stat.score;
                  best_row_in = row_ff;
                  found_in    = 1'b1;
               end
               row_in = row_ff + 1'b1;
            end
         end
         ST_CNT_WR: begin
            matched_in = 1'b1;
            seen_in    = cm_wdata;
         end
         default: begin
         end
      endcase
   end

   // result word register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_full_in     = rsp_full_ff;
      rsp_matched_in  = rsp_matched_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_sim_in      = rsp_sim_ff;
      rsp_seen_in     = rsp_seen_ff;
      rsp_enrolled_in = rsp_enrolled_ff;
      if (rsp_load) begin
         rsp_valid_in    = 1'b1;
         rsp_kind_in     = mode_ff;
         rsp_full_in     = full_ff;
         rsp_matched_in  = matched_ff;
         rsp_index_in    = matched_ff ? 6'(best_row_ff) : '0;
         rsp_sim_in      = (mode_ff == MODE_QUERY) ? best_ff : '0;
         rsp_seen_in     = matched_ff ? seen_ff : '0;
         rsp_enrolled_in = LIMIT_WIDTH'(enrolled_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= DEFAULT_THRESHOLD;
         limit_ff     <= LIMIT_RESET;
         enrolled_ff  <= '0;
         pos_ff       <= '0;
         mode_ff      <= MODE_ENROLL;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         limit_ff     <= limit_in;
         enrolled_ff  <= enrolled_in;
         pos_ff       <= pos_in;
         mode_ff      <= mode_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dim_ff          <= dim_in;
      e_ff            <= e_in;
      row_ff          <= row_in;
      dot_ff          <= dot_in;
      na_ff           <= na_in;
      nb_ff           <= nb_in;
      best_ff         <= best_in;
      best_row_ff     <= best_row_in;
      full_ff         <= full_in;
      matched_ff      <= matched_in;
      seen_ff         <= seen_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_full_ff     <= rsp_full_in;
      rsp_matched_ff  <= rsp_matched_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_sim_ff      <= rsp_sim_in;
      rsp_seen_ff     <= rsp_seen_in;
      rsp_enrolled_ff <= rsp_enrolled_in;
   end

   always_ff @(posedge clock) begin
      if (vm_we) vmem[vm_waddr] <= vm_wdata;
      v_data_ff <= vmem[vm_raddr];
   end

   always_ff @(posedge clock) begin
      if (qm_we) qmem[pos_ff[IW-1:0]] <= elem_val;
      q_data_ff <= qmem[e_ff[IW-1:0]];
   end

   // row being cleared on enroll, best row when bumping a match
   always_ff @(posedge clock) begin
      if (cm_we) begin
         if (state_ff == ST_FILL) cmem[RW'(enrolled_ff)] <= cm_wdata;
         else                     cmem[RW'(best_row_ff)] <= cm_wdata;
      end
      c_data_ff <= cmem[RW'(best_row_ff)];
   end

   cnm_score #(
      .NORM_WIDTH (NW)
   ) u_score (
      .clock (clock),
      .reset (reset),
      .start (score_start),
      .dot   (dot_ff),
      .na    (na_ff),
      .nb    (nb_ff),
      .stat  (stat)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = rsp_kind_ff;
   assign rsp_ch.table_full   = rsp_full_ff;
   assign rsp_ch.matched      = rsp_matched_ff;
   assign rsp_ch.person_index = rsp_index_ff;
   assign rsp_ch.similarity   = rsp_sim_ff;
   assign rsp_ch.seen_count   = rsp_seen_ff;
   assign rsp_ch.enrolled     = rsp_enrolled_ff;

   a_enrolled_bound: assert property (@(posedge clock) disable iff (reset)
      enrolled_ff <= CW'(TD))
      else $error("enrolled count beyond table depth");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(VL))
      else $error("position beyond vector length");

   a_found_positive: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (best_ff > 0))
      else $error("best marked found without a positive score");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("finished item left no result word");

endmodule

// ----- design/cnm_score.sv -----
// cnm_score: turns dot product and two norms into a Q1.15 cosine score
// with a bit-serial multiply, digit-serial square root and divide; uses cnm_pkg
`timescale 1ns / 1ps

module cnm_score import cnm_pkg::*; #(
   parameter int NORM_WIDTH = 2 * ELEMENT_WIDTH_DEF + $clog2(VECTOR_LENGTH_DEF)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [NORM_WIDTH:0]  dot,
   input  logic [NORM_WIDTH-1:0]       na,
   input  logic [NORM_WIDTH-1:0]       nb,
   output score_stat_type              stat
);

   localparam int NW  = NORM_WIDTH;
   localparam int CTW = $clog2(NW + 1);

   score_state_type sst_ff, sst_in;

   logic [NW-1:0]          a_ff, a_in;
   logic [NW-1:0]          b_ff, b_in;
   logic [2*NW-1:0]        p_ff, p_in;
   logic [NW+2:0]          rem_ff, rem_in;
   logic [NW-1:0]          root_ff, root_in;
   logic [NW:0]            rd_ff, rd_in;
   logic [NW-1:0]          mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [SCORE_WIDTH-1:0] q_ff, q_in;
   logic [CTW-1:0]         cnt_ff, cnt_in;
   logic signed [SCORE_WIDTH-1:0] score_ff, score_in;

   logic            low_norm;
   logic [NW:0]     dot_abs;
   logic [NW+2:0]   rem_shift;
   logic [NW+2:0]   trial;
   logic [NW:0]     div_sub;
   logic            div_ge;
   logic            last_step;
   logic            last_div;

   assign low_norm  = (na < NW'(NORM_FLOOR)) || (nb < NW'(NORM_FLOOR));
   assign dot_abs   = dot[NW] ? (NW+1)'(-dot) : $unsigned(dot);
   assign rem_shift = {rem_ff[NW:0], p_ff[2*NW-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign div_ge    = rd_ff >= {1'b0, root_ff};
   assign div_sub   = rd_ff - {1'b0, root_ff};
   assign last_step = cnt_ff == CTW'(NW - 1);
   assign last_div  = cnt_ff == CTW'(SCORE_WIDTH - 1);

   // next state
   always_comb begin
      sst_in = sst_ff;
      case (sst_ff)
         SC_IDLE: begin
            if (start) sst_in = low_norm ? SC_DONE : SC_MUL;
         end
         SC_MUL:  if (last_step) sst_in = SC_SQRT;
         SC_SQRT: if (last_step) sst_in = SC_PRE;
         SC_PRE:  sst_in = (root_ff == '0) ? SC_DONE : SC_DIV;
         SC_DIV:  if (last_div) sst_in = SC_FIN;
         SC_FIN:  sst_in = SC_DONE;
         SC_DONE: sst_in = SC_IDLE;
         default: sst_in = SC_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      p_in     = p_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      rd_in    = rd_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      score_in = score_ff;
      case (sst_ff)
         SC_IDLE: begin
            if (start) begin
               a_in     = na;
               b_in     = nb;
               p_in     = '0;
               cnt_in   = '0;
               mag_in   = NW'(dot_abs);
               neg_in   = dot[NW];
               score_in = '0;
            end
         end
         SC_MUL: begin
            // msb-first shift and add
            p_in   = (p_ff << 1) + (b_ff[NW-1] ? (2*NW)'(a_ff) : '0);
            b_in   = b_ff << 1;
            cnt_in = last_step ? '0 : cnt_ff + 1'b1;
            if (last_step) begin
               rem_in  = '0;
               root_in = '0;
            end
         end
         SC_SQRT: begin
            // one root bit per step, two product bits consumed
            if (rem_shift >= trial) begin
               rem_in  = rem_shift - trial;
               root_in = {root_ff[NW-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[NW-2:0], 1'b0};
            end
            p_in   = p_ff << 2;
            cnt_in = last_step ? '0 : cnt_ff + 1'b1;
         end
         SC_PRE: begin
            rd_in    = {1'b0, mag_ff};
            q_in     = '0;
            cnt_in   = '0;
            score_in = '0;
         end
         SC_DIV: begin
            // magnitude never exceeds the root, so the quotient fits
            q_in   = {q_ff[SCORE_WIDTH-2:0], div_ge};
            rd_in  = (div_ge ? div_sub : rd_ff) << 1;
            cnt_in = cnt_ff + 1'b1;
         end
         SC_FIN: begin
            if (neg_ff) begin
               score_in = SCORE_WIDTH'(-$signed({1'b0, q_ff}));
            end else if (q_ff[SCORE_WIDTH-1]) begin
               score_in = {1'b0, {(SCORE_WIDTH-1){1'b1}}};
            end else begin
               score_in = $signed(q_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sst_ff <= SC_IDLE;
      end else begin
         sst_ff <= sst_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      p_ff     <= p_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      rd_ff    <= rd_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      score_ff <= score_in;
   end

   assign stat.done  = sst_ff == SC_DONE;
   assign stat.score = score_ff;

endmodule
